// ----- rtl/jsv_pkg.sv -----
// Shared types, constants and literal tables for the JSON scalar validator.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package jsv_pkg;

	// Width of the internal string byte counter
	localparam int LEN_BITS = 16;
	// Width of the reported string length
	localparam int PLEN_W = 16;

	typedef enum logic [3:0] {
		PH_LEAD    = 4'd0,
		PH_LITERAL = 4'd1,
		PH_SIGN    = 4'd2,
		PH_ZERO    = 4'd3,
		PH_INT     = 4'd4,
		PH_DOT     = 4'd5,
		PH_FRAC    = 4'd6,
		PH_EXP     = 4'd7,
		PH_EXPSIGN = 4'd8,
		PH_EXPDIG  = 4'd9,
		PH_STRING  = 4'd10,
		PH_TRAIL   = 4'd11,
		PH_DONE    = 4'd12
	} phase_t;

	typedef enum logic [2:0] {
		ST_PENDING = 3'd0,
		ST_OK      = 3'd1,
		ST_EXPECT  = 3'd2,
		ST_INVALID = 3'd3,
		ST_NOTSING = 3'd4,
		ST_NOQUOTE = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		K_NONE   = 3'd0,
		K_NULL   = 3'd1,
		K_FALSE  = 3'd2,
		K_TRUE   = 3'd3,
		K_NUMBER = 3'd4,
		K_STRING = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		LIT_TRUE  = 2'd0,
		LIT_FALSE = 2'd1,
		LIT_NULL  = 2'd2,
		LIT_NULL2 = 2'd3
	} lit_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		kind_t             value_kind;
		logic [7:0]        payload_byte;
		logic              payload_valid;
		logic [PLEN_W-1:0] payload_length;
		logic              final_res;
	} out_item_t;

	// Scanner state carried from one byte to the next
	typedef struct packed {
		phase_t              phase;
		logic [2:0]          lit_pos;
		lit_t                lit_choice;
		logic [LEN_BITS-1:0] str_count;
		status_t             latched;
		kind_t               kind;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		phase:      PH_LEAD,
		lit_pos:    3'd0,
		lit_choice: LIT_TRUE,
		str_count:  '0,
		latched:    ST_PENDING,
		kind:       K_NONE
	};

	// Expected character of a literal at a given position
	function automatic logic [7:0] lit_char(lit_t choice, logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (choice)
			LIT_TRUE: begin
				case (pos)
					3'd0: c = "t";
					3'd1: c = "r";
					3'd2: c = "u";
					3'd3: c = "e";
					default: c = 8'h00;
				endcase
			end
			LIT_FALSE: begin
				case (pos)
					3'd0: c = "f";
					3'd1: c = "a";
					3'd2: c = "l";
					3'd3: c = "s";
					3'd4: c = "e";
					default: c = 8'h00;
				endcase
			end
			default: begin
				case (pos)
					3'd0: c = "n";
					3'd1: c = "u";
					3'd2: c = "l";
					3'd3: c = "l";
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [2:0] lit_len(lit_t choice);
		return (choice == LIT_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic kind_t lit_kind(lit_t choice);
		kind_t k;
		case (choice)
			LIT_TRUE:  k = K_TRUE;
			LIT_FALSE: k = K_FALSE;
			default:   k = K_NULL;
		endcase
		return k;
	endfunction

	// Clamp the counter to the reported length width
	function automatic logic [PLEN_W-1:0] sat_len(logic [LEN_BITS-1:0] cnt);
		logic [31:0] wide;
		wide = 32'(cnt);
		return (wide > 32'(2 ** PLEN_W - 1)) ? {PLEN_W{1'b1}} : wide[PLEN_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/jsv_in_if.sv -----
// Input channel of the JSON scalar validator: valid/ready plus one text byte item.
// Depends on jsv_pkg.
`default_nettype none

interface jsv_in_if;
	logic               valid;
	logic               ready;
	jsv_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/jsv_out_if.sv -----
// Result channel of the JSON scalar validator: valid/ready plus one result item.
// Depends on jsv_pkg.
`default_nettype none

interface jsv_out_if;
	logic                valid;
	logic                ready;
	jsv_pkg::out_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/json_scalar_validator_core.sv -----
// JSON scalar validator: top level with input register, scanner state and result register.
// Depends on jsv_pkg, jsv_in_if, jsv_out_if and jsv_step.
//
// Usage:
//   text   - sink channel; each transfer carries one text byte, or the end marker
//            (end_of_text = 1), which stands for the terminating NUL of the text.
//   report - source channel; exactly one result item per input transfer, in order.
//   Each result gives the running status (pending until an error is latched or
//   the end marker arrives), the value kind seen so far, the string content byte
//   of this step if any, and the saturating string length.
//   A byte transferred on text passes the input register, then the result register,
//   before it is presented on report. Throughput: one byte per cycle while report
//   takes results, set by the single scanner step between the two registers.
//   The end marker returns the scanner to its start state for the next text.
//   Reset (arst_n low) empties both registers and puts the scanner in its start
//   state. When report stalls, the result is held, one more byte waits in the
//   input register, and text drops ready until the result is taken.
`default_nettype none

module json_scalar_validator_core (
	input  wire        clk,
	input  wire        arst_n,
	jsv_in_if.sink     text,
	jsv_out_if.source  report
);

	logic                  valid_s1;
	jsv_pkg::in_item_t     item_s1;
	jsv_pkg::scan_state_t  state_q;
	jsv_pkg::scan_state_t  state_nxt;
	jsv_pkg::out_item_t    res;
	logic                  out_valid_q;
	jsv_pkg::out_item_t    out_q;
	logic                  advance;

	// Move the held byte forward when the result register is free or draining
	assign advance    = valid_s1 && (!out_valid_q || report.ready);
	assign text.ready = !valid_s1 || advance;

	jsv_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	// Hold the input byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			item_s1 <= text.data;
		end
	end

	// Advance the scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jsv_pkg::SCAN_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Hold the result until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign report.valid = out_valid_q;
	assign report.data  = out_q;

endmodule

`default_nettype wire

// ----- rtl/jsv_step.sv -----
// One scanner step: next scanner state and the result item for one text byte.
// Purely combinational; depends on jsv_pkg.
`default_nettype none

module jsv_step (
	input  wire jsv_pkg::scan_state_t cur,
	input  wire jsv_pkg::in_item_t    item,
	output jsv_pkg::scan_state_t      nxt,
	output jsv_pkg::out_item_t        res
);

	function automatic logic is_ws(logic [7:0] b);
		return (b == " ") || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	logic [7:0]    b;
	logic [2:0]    pos_inc;
	logic [2:0]    llen;
	logic          pvalid;
	jsv_pkg::status_t end_st;
	jsv_pkg::kind_t   end_kind;

	assign b       = item.text_byte;
	assign llen    = jsv_pkg::lit_len(cur.lit_choice);
	assign pos_inc = cur.lit_pos + 3'd1;

	// Advance the phase machine by one byte
	always_comb begin
		nxt    = cur;
		pvalid = 1'b0;
		case (cur.phase)
			jsv_pkg::PH_LEAD: begin
				if (is_ws(b)) begin
					nxt.phase = jsv_pkg::PH_LEAD;
				end else if (b == "t" || b == "f" || b == "n") begin
					nxt.lit_choice = (b == "t") ? jsv_pkg::LIT_TRUE :
						((b == "f") ? jsv_pkg::LIT_FALSE : jsv_pkg::LIT_NULL);
					nxt.lit_pos = 3'd1;
					nxt.phase   = jsv_pkg::PH_LITERAL;
				end else if (b == "\"") begin
					nxt.phase = jsv_pkg::PH_STRING;
				end else if (b == "-") begin
					nxt.phase = jsv_pkg::PH_SIGN;
				end else if (b == "0") begin
					nxt.phase = jsv_pkg::PH_ZERO;
				end else if (is_digit(b)) begin
					nxt.phase = jsv_pkg::PH_INT;
				end else begin
					nxt.latched = jsv_pkg::ST_INVALID;
					nxt.phase   = jsv_pkg::PH_DONE;
				end
			end
			jsv_pkg::PH_LITERAL: begin
				if (cur.lit_pos >= llen || b != jsv_pkg::lit_char(cur.lit_choice, cur.lit_pos)) begin
					nxt.latched = jsv_pkg::ST_INVALID;
					nxt.phase   = jsv_pkg::PH_DONE;
				end else begin
					nxt.lit_pos = pos_inc;
					if (pos_inc >= llen) begin
						nxt.kind  = jsv_pkg::lit_kind(cur.lit_choice);
						nxt.phase = jsv_pkg::PH_TRAIL;
					end
				end
			end
			jsv_pkg::PH_SIGN: begin
				if (b == "0") begin
					nxt.phase = jsv_pkg::PH_ZERO;
				end else if (is_digit(b)) begin
					nxt.phase = jsv_pkg::PH_INT;
				end else begin
					nxt.latched = jsv_pkg::ST_INVALID;
					nxt.phase   = jsv_pkg::PH_DONE;
				end
			end
			jsv_pkg::PH_ZERO, jsv_pkg::PH_INT, jsv_pkg::PH_FRAC, jsv_pkg::PH_EXPDIG: begin
				if (cur.phase != jsv_pkg::PH_ZERO && is_digit(b)) begin
					nxt.phase = cur.phase;
				end else if (b == "." &&
						(cur.phase == jsv_pkg::PH_ZERO || cur.phase == jsv_pkg::PH_INT)) begin
					nxt.phase = jsv_pkg::PH_DOT;
				end else if ((b == "e" || b == "E") && cur.phase != jsv_pkg::PH_EXPDIG) begin
					nxt.phase = jsv_pkg::PH_EXP;
				end else begin
					// number ends here; judge the byte as trailing text
					nxt.kind = jsv_pkg::K_NUMBER;
					if (is_ws(b)) begin
						nxt.phase = jsv_pkg::PH_TRAIL;
					end else begin
						nxt.latched = jsv_pkg::ST_NOTSING;
						nxt.phase   = jsv_pkg::PH_DONE;
					end
				end
			end
			jsv_pkg::PH_DOT, jsv_pkg::PH_EXPSIGN: begin
				if (is_digit(b)) begin
					nxt.phase = (cur.phase == jsv_pkg::PH_DOT) ? jsv_pkg::PH_FRAC :
						jsv_pkg::PH_EXPDIG;
				end else begin
					nxt.latched = jsv_pkg::ST_INVALID;
					nxt.phase   = jsv_pkg::PH_DONE;
				end
			end
			jsv_pkg::PH_EXP: begin
				if (b == "+" || b == "-") begin
					nxt.phase = jsv_pkg::PH_EXPSIGN;
				end else if (is_digit(b)) begin
					nxt.phase = jsv_pkg::PH_EXPDIG;
				end else begin
					nxt.latched = jsv_pkg::ST_INVALID;
					nxt.phase   = jsv_pkg::PH_DONE;
				end
			end
			jsv_pkg::PH_STRING: begin
				if (b == "\"") begin
					nxt.kind  = jsv_pkg::K_STRING;
					nxt.phase = jsv_pkg::PH_TRAIL;
				end else begin
					pvalid = 1'b1;
					if (cur.str_count != {jsv_pkg::LEN_BITS{1'b1}}) begin
						nxt.str_count = cur.str_count + 1'b1;
					end
				end
			end
			jsv_pkg::PH_TRAIL: begin
				if (!is_ws(b)) begin
					nxt.latched = jsv_pkg::ST_NOTSING;
					nxt.phase   = jsv_pkg::PH_DONE;
				end
			end
			default: begin
				nxt.phase = jsv_pkg::PH_DONE;
			end
		endcase

		// end marker: report and return to the start state
		if (item.end_of_text) begin
			nxt    = jsv_pkg::SCAN_RESET;
			pvalid = 1'b0;
		end
	end

	// Final status when the end marker arrives
	always_comb begin
		end_kind = cur.kind;
		case (cur.phase)
			jsv_pkg::PH_LEAD:   end_st = jsv_pkg::ST_EXPECT;
			jsv_pkg::PH_ZERO, jsv_pkg::PH_INT, jsv_pkg::PH_FRAC, jsv_pkg::PH_EXPDIG: begin
				end_st   = jsv_pkg::ST_OK;
				end_kind = jsv_pkg::K_NUMBER;
			end
			jsv_pkg::PH_STRING: end_st = jsv_pkg::ST_NOQUOTE;
			jsv_pkg::PH_TRAIL:  end_st = jsv_pkg::ST_OK;
			jsv_pkg::PH_DONE:   end_st = cur.latched;
			default:            end_st = jsv_pkg::ST_INVALID;
		endcase
	end

	// Assemble the result item
	always_comb begin
		res.payload_byte  = pvalid ? b : 8'h00;
		res.payload_valid = pvalid;
		if (item.end_of_text) begin
			res.status         = end_st;
			res.value_kind     = end_kind;
			res.payload_length = jsv_pkg::sat_len(cur.str_count);
			res.final_res      = 1'b1;
		end else begin
			res.status         = (nxt.phase == jsv_pkg::PH_DONE) ? nxt.latched :
				jsv_pkg::ST_PENDING;
			res.value_kind     = nxt.kind;
			res.payload_length = jsv_pkg::sat_len(nxt.str_count);
			res.final_res      = (nxt.phase == jsv_pkg::PH_DONE);
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for json_scalar_validator_core: streams JSON texts byte by byte and
// checks every result item against a built-in scanner model. Uses jsv_pkg, jsv_in_if and jsv_out_if.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import jsv_pkg::*;

	typedef logic [7:0] text_q_t[$];

	localparam int RANDOM_ITEMS = 1150;
	localparam int LONG_STRING  = 65540;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int SHOW_LIMIT   = 100;

	// Scanner model plus the queue of results it expects, oldest first
	class scan_scoreboard;
		phase_t              ph;
		logic [2:0]          lit_pos;
		lit_t                lit_sel;
		logic [LEN_BITS-1:0] str_cnt;
		status_t             held;
		kind_t               seen;
		out_item_t           expected_q[$];
		int                  errors;
		int                  results;
		int                  texts;
		int                  string_bytes;
		int                  ends_by_status[8];

		function new();
			restart();
		endfunction

		function void restart();
			ph = PH_LEAD;
			lit_pos = 3'd0;
			lit_sel = LIT_TRUE;
			str_cnt = '0;
			held = ST_PENDING;
			seen = K_NONE;
		endfunction

		function bit is_space(logic [7:0] b);
			return b == " " || b == 8'h09 || b == 8'h0a || b == 8'h0d;
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function string lit_word(lit_t sel);
			case (sel)
				LIT_TRUE:  return "true";
				LIT_FALSE: return "false";
				default:   return "null";
			endcase
		endfunction

		function void latch(status_t s);
			held = s;
			ph = PH_DONE;
		endfunction

		// Judge the byte that follows a complete value
		function void after_value(logic [7:0] b);
			if (is_space(b))
				ph = PH_TRAIL;
			else
				latch(ST_NOTSING);
		endfunction

		function void number_done(logic [7:0] b);
			seen = K_NUMBER;
			after_value(b);
		endfunction

		function status_t closing_status();
			case (ph)
				PH_LEAD: return ST_EXPECT;
				PH_ZERO, PH_INT, PH_FRAC, PH_EXPDIG: begin
					seen = K_NUMBER;
					return ST_OK;
				end
				PH_STRING: return ST_NOQUOTE;
				PH_TRAIL:  return ST_OK;
				PH_DONE:   return held;
				default:   return ST_INVALID;
			endcase
		endfunction

		// Advance the model by one accepted transfer; returns 1 if the byte was not ignored
		function bit note_text(in_item_t it);
			out_item_t want;
			logic [7:0] b;
			bit         live;
			string      word;
			b = it.text_byte;
			want = '0;
			live = it.end_of_text || (ph != PH_DONE);
			if (it.end_of_text) begin
				want.status = closing_status();
				want.final_res = 1'b1;
			end else begin
				case (ph)
					PH_LEAD: begin
						if (b == "t" || b == "f" || b == "n") begin
							lit_sel = (b == "t") ? LIT_TRUE : ((b == "f") ? LIT_FALSE : LIT_NULL);
							lit_pos = 3'd1;
							ph = PH_LITERAL;
						end else if (b == "\"")
							ph = PH_STRING;
						else if (b == "-")
							ph = PH_SIGN;
						else if (b == "0")
							ph = PH_ZERO;
						else if (is_digit(b))
							ph = PH_INT;
						else if (!is_space(b))
							latch(ST_INVALID);
					end
					PH_LITERAL: begin
						word = lit_word(lit_sel);
						if (lit_pos >= word.len() || b != 8'(word[lit_pos]))
							latch(ST_INVALID);
						else begin
							lit_pos++;
							if (lit_pos >= word.len()) begin
								case (lit_sel)
									LIT_TRUE:  seen = K_TRUE;
									LIT_FALSE: seen = K_FALSE;
									default:   seen = K_NULL;
								endcase
								ph = PH_TRAIL;
							end
						end
					end
					PH_SIGN: begin
						if (b == "0")
							ph = PH_ZERO;
						else if (is_digit(b))
							ph = PH_INT;
						else
							latch(ST_INVALID);
					end
					PH_ZERO, PH_INT: begin
						if (!(ph == PH_INT && is_digit(b))) begin
							if (b == ".")
								ph = PH_DOT;
							else if (b == "e" || b == "E")
								ph = PH_EXP;
							else
								number_done(b);
						end
					end
					PH_DOT: begin
						if (is_digit(b))
							ph = PH_FRAC;
						else
							latch(ST_INVALID);
					end
					PH_FRAC: begin
						if (!is_digit(b)) begin
							if (b == "e" || b == "E")
								ph = PH_EXP;
							else
								number_done(b);
						end
					end
					PH_EXP: begin
						if (b == "+" || b == "-")
							ph = PH_EXPSIGN;
						else if (is_digit(b))
							ph = PH_EXPDIG;
						else
							latch(ST_INVALID);
					end
					PH_EXPSIGN: begin
						if (is_digit(b))
							ph = PH_EXPDIG;
						else
							latch(ST_INVALID);
					end
					PH_EXPDIG: begin
						if (!is_digit(b))
							number_done(b);
					end
					PH_STRING: begin
						if (b == "\"") begin
							seen = K_STRING;
							ph = PH_TRAIL;
						end else begin
							want.payload_byte = b;
							want.payload_valid = 1'b1;
							string_bytes++;
							// hold the count at its maximum
							if (str_cnt != '1)
								str_cnt++;
						end
					end
					PH_TRAIL: after_value(b);
					default: ph = PH_DONE;
				endcase
				want.status = (ph == PH_DONE) ? held : ST_PENDING;
				want.final_res = (ph == PH_DONE);
			end
			want.value_kind = seen;
			want.payload_length = str_cnt;
			expected_q.push_back(want);
			if (it.end_of_text) begin
				texts++;
				ends_by_status[want.status]++;
				restart();
			end
			return live;
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		// Compare one result transfer with the oldest expectation
		function void check_report(out_item_t got);
			out_item_t want;
			results++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("%0t: unexpected result: expected none, actual %0h", $time, got);
				return;
			end
			want = expected_q.pop_front();
			compare("status", want.status, got.status);
			compare("value_kind", want.value_kind, got.value_kind);
			compare("payload_byte", want.payload_byte, got.payload_byte);
			compare("payload_valid", want.payload_valid, got.payload_valid);
			compare("payload_length", want.payload_length, got.payload_length);
			compare("final_res", want.final_res, got.final_res);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   live_sent;
	int   idle_cycles;

	jsv_in_if  text_ch();
	jsv_out_if report_ch();

	scan_scoreboard sb = new();

	json_scalar_validator_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.report (report_ch)
	);

	// Clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 3))
			0: return " ";
			1: return 8'h09;
			2: return 8'h0a;
			default: return 8'h0d;
		endcase
	endfunction

	// Bytes that tend to steer the scanner somewhere interesting
	function automatic logic [7:0] pick_tricky();
		string pool;
		pool = "0123456789.eE+-\"tfnrulsa x,";
		if ($urandom_range(0, 1))
			return 8'(pool[$urandom_range(0, pool.len() - 1)]);
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void add_digits(ref text_q_t q, input int n);
		repeat (n) q.push_back(8'("0" + $urandom_range(0, 9)));
	endfunction

	// Build one text: mostly well-formed values, some broken, a little pure noise
	function automatic text_q_t random_text();
		text_q_t    q;
		int         sel;
		int         k;
		string      word;
		logic [7:0] b;
		q = {};
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			repeat ($urandom_range(0, 8)) q.push_back(8'($urandom_range(0, 255)));
			return q;
		end
		repeat ($urandom_range(0, 2)) q.push_back(pick_space());
		case ($urandom_range(0, 2))
			0: begin
				case ($urandom_range(0, 2))
					0: word = "true";
					1: word = "false";
					default: word = "null";
				endcase
				for (int i = 0; i < word.len(); i++)
					q.push_back(8'(word[i]));
			end
			1: begin
				if ($urandom_range(0, 2) == 0)
					q.push_back("-");
				if ($urandom_range(0, 2) == 0)
					q.push_back("0");
				else begin
					q.push_back(8'("1" + $urandom_range(0, 8)));
					add_digits(q, $urandom_range(0, 4));
				end
				if ($urandom_range(0, 1)) begin
					q.push_back(".");
					add_digits(q, $urandom_range(1, 3));
				end
				if ($urandom_range(0, 4) < 2) begin
					q.push_back($urandom_range(0, 1) ? "e" : "E");
					case ($urandom_range(0, 2))
						0: q.push_back("+");
						1: q.push_back("-");
						default: ;
					endcase
					add_digits(q, $urandom_range(1, 2));
				end
			end
			default: begin
				q.push_back("\"");
				repeat ($urandom_range(0, 10)) begin
					b = 8'($urandom_range(0, 255));
					q.push_back((b == "\"") ? 8'h27 : b);
				end
				q.push_back("\"");
			end
		endcase
		repeat ($urandom_range(0, 2)) q.push_back(pick_space());
		// break some of them
		if (sel < 35) begin
			case ($urandom_range(0, 3))
				0: begin
					k = $urandom_range(0, q.size() - 1);
					while (q.size() > k) void'(q.pop_back());
				end
				1: q[$urandom_range(0, q.size() - 1)] = pick_tricky();
				2: repeat ($urandom_range(1, 3)) q.push_back(pick_tricky());
				default: q.insert($urandom_range(0, q.size()), pick_tricky());
			endcase
		end
		return q;
	endfunction

	// Offer one item on the text channel and wait for its transfer
	task automatic send_item(input logic [7:0] b, input logic eot);
		in_item_t it;
		int       gap;
		it.text_byte = b;
		it.end_of_text = eot;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data <= it;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		if (sb.note_text(it))
			live_sent++;
		@(negedge clk);
	endtask

	// Send a text followed by the end marker, whose byte field is don't-care
	task automatic send_text(input text_q_t q);
		foreach (q[i]) send_item(q[i], 1'b0);
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Result side: random stalls of varying length, none while calm
	initial begin
		int run;
		report_ch.ready = 1'b0;
		run = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm) begin
				report_ch.ready <= 1'b1;
				run = 0;
			end else if (run > 0)
				run--;
			else if ($urandom_range(0, 99) < 65) begin
				report_ch.ready <= 1'b1;
				run = $urandom_range(0, 15);
			end else begin
				report_ch.ready <= 1'b0;
				run = pick_gap();
			end
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && report_ch.valid && report_ch.ready)
			sb.check_report(report_ch.data);
	end

	// Stop a hung run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (report_ch.valid && report_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		text_q_t    q;
		int         base;
		logic [7:0] lb;
		arst_n = 1'b0;
		calm = 1'b0;
		live_sent = 0;
		idle_cycles = 0;
		text_ch.valid = 1'b0;
		text_ch.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty text
		q = {};
		send_text(q);
		// byte that cannot start a value
		q = {"x"};
		send_text(q);
		// literal cut short
		q = {"t", "r", "u"};
		send_text(q);
		// number cut short after the sign
		q = {"-"};
		send_text(q);
		// string without its closing quote
		q = {"\"", "a"};
		send_text(q);
		// leading zero ends the number, the next digit is trailing text
		q = {"0", "1", "2", "3"};
		send_text(q);
		// zero byte is an ordinary bad byte
		q = {8'h00};
		send_text(q);
		// literal with trailing space
		q = {"n", "u", "l", "l", " "};
		send_text(q);
		// top byte value inside a string
		q = {"\"", 8'hff, "\""};
		send_text(q);

		// random texts, with occasional stretches of no idling
		base = live_sent;
		while (live_sent - base < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 9) == 0);
			send_text(random_text());
		end

		// one string long enough to saturate the length counter
		calm = 1'b1;
		q = {"\""};
		repeat (LONG_STRING) begin
			lb = 8'($urandom_range(0, 254));
			q.push_back((lb == 8'h22) ? 8'h23 : lb);
		end
		q.push_back("\"");
		send_text(q);
		calm = 1'b0;
		text_ch.valid <= 1'b0;

		// drain
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			sb.errors++;
			$display("%0t: results missing: expected %0d more, actual 0",
				$time, sb.expected_q.size());
		end

		$display("Checked %0d results over %0d texts (%0d string bytes, one saturating string).",
			sb.results, sb.texts, sb.string_bytes);
		$display("Final status counts: ok %0d, expect %0d, invalid %0d, notsing %0d, noquote %0d",
			sb.ends_by_status[ST_OK], sb.ends_by_status[ST_EXPECT],
			sb.ends_by_status[ST_INVALID], sb.ends_by_status[ST_NOTSING],
			sb.ends_by_status[ST_NOQUOTE]);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
